### rtl/c3f_pkg.sv
// Types and constants shared by the 3x3 image convolution filter.
// No dependencies.
package c3f_pkg;

  localparam int unsigned CH_W     = 8;
  localparam int unsigned PIX_W    = 3 * CH_W;
  localparam int unsigned SIZE_W   = 12;
  localparam int unsigned COEF_W   = 16;
  localparam int unsigned CROW_W   = 3 * COEF_W;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned PROD_W   = 24;
  localparam int unsigned RSUM_W   = 26;
  localparam int unsigned TSUM_W   = 28;
  localparam int unsigned FRAC_W   = 11;

  localparam logic [CROW_W-1:0] COEF_RESET   = 48'h00E4_00E4_00E4;
  localparam logic [SIZE_W-1:0] WIDTH_RESET  = 12'd640;
  localparam logic [SIZE_W-1:0] HEIGHT_RESET = 12'd480;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_COLOR_MODE = 3'd0,
    CFG_WIDTH      = 3'd1,
    CFG_HEIGHT     = 3'd2,
    CFG_COEF_TOP   = 3'd3,
    CFG_COEF_MID   = 3'd4,
    CFG_COEF_BOT   = 3'd5
  } cfg_idx_e;

  typedef struct packed {
    logic [CH_W-1:0] red_in;
    logic [CH_W-1:0] green_in;
    logic [CH_W-1:0] blue_in;
  } pix_in_t;

  typedef struct packed {
    logic [CH_W-1:0] red_out;
    logic [CH_W-1:0] green_out;
    logic [CH_W-1:0] blue_out;
    logic            frame_last;
  } pix_out_t;

  // red in [7:0], green in [15:8], blue in [23:16]
  typedef logic [PIX_W-1:0] rgb_t;
  // [row: 0 top][col: 0 left]
  typedef rgb_t [2:0][2:0] win_t;
  // [row: 0 top], left coefficient in bits 15..0
  typedef logic [2:0][CROW_W-1:0] coef_set_t;

  typedef struct packed {
    logic valid;
    logic color;
    logic last;
  } win_ctrl_t;

endpackage

### rtl/c3f_ram.sv
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
module c3f_ram #(
  parameter int unsigned WIDTH = 48,
  parameter int unsigned DEPTH = 2048
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/c3f_window.sv
// Raster counters, line store and 3x3 window of the convolution filter.
// Depends on c3f_pkg and c3f_ram.
module c3f_window import c3f_pkg::*; #(
  parameter int unsigned MAX_WIDTH  = 2048,
  parameter int unsigned MAX_HEIGHT = 2048
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              in_valid_i,
  input  pix_in_t           in_data_i,
  input  logic              color_mode_i,
  input  logic [SIZE_W-1:0] image_width_i,
  input  logic [SIZE_W-1:0] image_height_i,
  output win_t              win_o,
  output win_ctrl_t         ctrl_o
);

  localparam int unsigned CW  = $clog2(MAX_WIDTH);
  localparam int unsigned RW  = $clog2(MAX_HEIGHT);
  localparam int unsigned SW0 = (CW > RW) ? CW + 1 : RW + 1;
  localparam int unsigned SW  = (SW0 > SIZE_W) ? SW0 : SIZE_W + 1;

  logic [CW-1:0]   col_q, col_d;
  logic [RW-1:0]   row_q, row_d;
  logic [SW-1:0]   w_eff, h_eff, w_in, h_in;
  logic            accept, line_end, frame_end, produce;

  logic            s1_vld_q;
  win_ctrl_t       s1_q;
  rgb_t            pix_q;
  logic [CW-1:0]   addr_q;
  logic [2*PIX_W-1:0] rd_data;

  win_t            win_q;
  win_ctrl_t       ctrl_q;

  assign accept = in_valid_i & en_i;

  assign w_in  = SW'(image_width_i);
  assign h_in  = SW'(image_height_i);
  assign w_eff = (w_in < SW'(3)) ? SW'(3) :
                 (w_in > SW'(MAX_WIDTH)) ? SW'(MAX_WIDTH) : w_in;
  assign h_eff = (h_in < SW'(3)) ? SW'(3) :
                 (h_in > SW'(MAX_HEIGHT)) ? SW'(MAX_HEIGHT) : h_in;

  assign line_end  = SW'(col_q) >= (w_eff - SW'(1));
  assign frame_end = line_end && (SW'(row_q) >= (h_eff - SW'(1)));
  assign produce   = (row_q >= RW'(2)) && (col_q >= CW'(2));

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (line_end) begin
      col_d = '0;
      row_d = frame_end ? '0 : row_q + RW'(1);
    end else begin
      col_d = col_q + CW'(1);
    end
  end

  // Line store: [47:24] two lines up, [23:0] one line up. Consecutive words
  // never share a column, so the write-back never meets the next read.
  c3f_ram #(
    .WIDTH (2 * PIX_W),
    .DEPTH (MAX_WIDTH)
  ) u_line_ram (
    .clk_i   (clk_i),
    .we_i    (en_i & s1_vld_q),
    .waddr_i (addr_q),
    .wdata_i ({rd_data[PIX_W-1:0], pix_q}),
    .re_i    (accept),
    .raddr_i (col_q),
    .rdata_o (rd_data)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q    <= '0;
      row_q    <= '0;
      s1_vld_q <= 1'b0;
      s1_q     <= '0;
      win_q    <= '0;
      ctrl_q   <= '0;
    end else if (en_i) begin
      s1_vld_q <= accept;
      if (accept) begin
        col_q      <= col_d;
        row_q      <= row_d;
        s1_q.valid <= produce;
        s1_q.color <= color_mode_i;
        s1_q.last  <= frame_end;
      end
      ctrl_q <= s1_vld_q ? s1_q : '0;
      if (s1_vld_q) begin
        for (int n = 0; n < 3; n++) begin
          win_q[n][0] <= win_q[n][1];
          win_q[n][1] <= win_q[n][2];
        end
        win_q[0][2] <= rd_data[2*PIX_W-1:PIX_W];
        win_q[1][2] <= rd_data[PIX_W-1:0];
        win_q[2][2] <= pix_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      pix_q  <= {in_data_i.blue_in, in_data_i.green_in, in_data_i.red_in};
      addr_q <= col_q;
    end
  end

  assign win_o  = win_q;
  assign ctrl_o = ctrl_q;

endmodule

### rtl/c3f_conv.sv
// Multiply, row-sum and clamp pipeline of the 3x3 convolution.
// Depends on c3f_pkg.
module c3f_conv import c3f_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      en_i,
  input  win_t      win_i,
  input  win_ctrl_t ctrl_i,
  input  coef_set_t coef_i,
  output logic      res_valid_o,
  output pix_out_t  res_o
);

  logic signed [PROD_W-1:0] prod_q [3][3][3];
  logic signed [RSUM_W-1:0] rsum_q [3][3];
  win_ctrl_t                c3_q, c4_q;
  logic signed [TSUM_W-1:0] tsum [3];
  logic [CH_W-1:0]          clamped [3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c3_q <= '0;
      c4_q <= '0;
    end else if (en_i) begin
      c3_q <= ctrl_i;
      c4_q <= c3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int ch = 0; ch < 3; ch++) begin
        for (int n = 0; n < 3; n++) begin
          for (int m = 0; m < 3; m++) begin
            prod_q[ch][n][m] <=
              PROD_W'($signed(coef_i[n][m*COEF_W +: COEF_W])) *
              PROD_W'($signed({1'b0, win_i[n][m][ch*CH_W +: CH_W]}));
          end
          rsum_q[ch][n] <= RSUM_W'(prod_q[ch][n][0]) + RSUM_W'(prod_q[ch][n][1]) +
                           RSUM_W'(prod_q[ch][n][2]);
        end
      end
    end
  end

  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      tsum[ch] = TSUM_W'(rsum_q[ch][0]) + TSUM_W'(rsum_q[ch][1]) +
                 TSUM_W'(rsum_q[ch][2]);
      if (tsum[ch][TSUM_W-1]) begin
        clamped[ch] = '0;
      end else if (|tsum[ch][TSUM_W-2:FRAC_W+CH_W]) begin
        clamped[ch] = '1;
      end else begin
        clamped[ch] = tsum[ch][FRAC_W +: CH_W];
      end
    end
  end

  assign res_valid_o      = c4_q.valid;
  assign res_o.red_out    = clamped[0];
  assign res_o.green_out  = c4_q.color ? clamped[1] : '0;
  assign res_o.blue_out   = c4_q.color ? clamped[2] : '0;
  assign res_o.frame_last = c4_q.last;

endmodule

### rtl/conv3x3_image_filter.sv
// Top level of the 3x3 image convolution filter: config registers, output skid.
// Depends on c3f_pkg, c3f_window, c3f_conv (and c3f_ram below them).
//
//   channel  direction  handshake                 word
//   in       input      in_valid_i / in_ready_o   pix_in_t
//   out      output     out_valid_o / out_ready_i pix_out_t
//   cfg      input      cfg_valid_i / cfg_ready_o index + 48-bit data
//
// One pixel per cycle sustained while the skid register is empty. The result of
// the pixel completing a window passes line-store read, window, multiply and
// row-sum registers, then total and clamp, into the output register. A skid
// register behind it takes one result while out_ready_i is low; only when it
// fills does the whole pipeline hold. Reset clears counters, window and
// control; line store has no clearing pass. Config writes are always taken.
module conv3x3_image_filter import c3f_pkg::*; #(
  parameter int unsigned MAX_WIDTH  = 2048,
  parameter int unsigned MAX_HEIGHT = 2048
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  pix_in_t              in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output pix_out_t             out_data_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [CROW_W-1:0]    cfg_data_i
);

  logic              color_mode_q;
  logic [SIZE_W-1:0] width_q, height_q;
  coef_set_t         coef_q;

  logic      en;
  win_t      win;
  win_ctrl_t win_ctrl;
  logic      res_valid;
  pix_out_t  res;

  logic      out_vld_q, skid_vld_q;
  pix_out_t  out_q, skid_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      color_mode_q <= 1'b0;
      width_q      <= WIDTH_RESET;
      height_q     <= HEIGHT_RESET;
      coef_q       <= {COEF_RESET, COEF_RESET, COEF_RESET};
    end else if (cfg_valid_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_COLOR_MODE: color_mode_q <= cfg_data_i[0];
        CFG_WIDTH:      width_q      <= cfg_data_i[SIZE_W-1:0];
        CFG_HEIGHT:     height_q     <= cfg_data_i[SIZE_W-1:0];
        CFG_COEF_TOP:   coef_q[0]    <= cfg_data_i;
        CFG_COEF_MID:   coef_q[1]    <= cfg_data_i;
        CFG_COEF_BOT:   coef_q[2]    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign en         = !skid_vld_q;
  assign in_ready_o = en;

  c3f_window #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_window (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .en_i           (en),
    .in_valid_i     (in_valid_i),
    .in_data_i      (in_data_i),
    .color_mode_i   (color_mode_q),
    .image_width_i  (width_q),
    .image_height_i (height_q),
    .win_o          (win),
    .ctrl_o         (win_ctrl)
  );

  c3f_conv u_conv (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (en),
    .win_i       (win),
    .ctrl_i      (win_ctrl),
    .coef_i      (coef_q),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else if (en) begin
      if (res_valid) begin
        if (!out_vld_q || out_ready_i) begin
          out_vld_q <= 1'b1;
        end else begin
          skid_vld_q <= 1'b1;
        end
      end else if (out_ready_i) begin
        out_vld_q <= 1'b0;
      end
    end else if (out_ready_i) begin
      skid_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      if (res_valid) begin
        if (!out_vld_q || out_ready_i) begin
          out_q <= res;
        end else begin
          skid_q <= res;
        end
      end
    end else if (out_ready_i) begin
      out_q <= skid_q;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

endmodule

### tb/conv3x3_image_filter_test.sv
// Self-checking testbench for conv3x3_image_filter: drives raster pixels and config words,
// predicts each filtered pixel and compares results in order.
// Depends on c3f_pkg and the conv3x3_image_filter RTL.
module conv3x3_image_filter_test;
  import c3f_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned MAX_W         = 2048;
  localparam int unsigned MAX_H         = 2048;
  localparam int unsigned IDLE_PCT      = 22;
  localparam int unsigned SETTLE_CYCLES = 12;
  localparam int unsigned STALL_LIMIT   = 2000;
  localparam int unsigned HOLD_CYCLES   = 400;
  localparam int unsigned STEADY_AT     = 200;
  localparam int unsigned STEADY_CYCLES = 600;
  localparam int unsigned RANDOM_PIXELS = 280;
  localparam int unsigned PRINT_CAP     = 100;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;

  typedef enum logic [1:0] {PIX_RANDOM, PIX_WHITE, PIX_BLACK} fill_e;

  logic                 clk_i       = 1'b0;
  logic                 rst_ni      = 1'b0;
  logic                 in_valid_i  = 1'b0;
  logic                 in_ready_o;
  pix_in_t              in_data_i   = '0;
  logic                 out_valid_o;
  logic                 out_ready_i = 1'b0;
  pix_out_t             out_data_o;
  logic                 cfg_valid_i = 1'b0;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [CROW_W-1:0]    cfg_data_i  = '0;

  conv3x3_image_filter #(
    .MAX_WIDTH  (MAX_W),
    .MAX_HEIGHT (MAX_H)
  ) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  // filter model state
  logic              color_rgb = 1'b0;
  logic [SIZE_W-1:0] img_w     = WIDTH_RESET;
  logic [SIZE_W-1:0] img_h     = HEIGHT_RESET;
  coef_set_t         coefs     = {COEF_RESET, COEF_RESET, COEF_RESET};
  rgb_t              line_a [MAX_W];
  rgb_t              line_b [MAX_W];
  bit                seen_a [MAX_W];
  bit                seen_b [MAX_W];
  win_t              window    = '0;
  int unsigned       col_pos   = 0;
  int unsigned       row_pos   = 0;

  pix_out_t    filtered_due [$];
  pix_in_t     pixel_backlog [$];
  int unsigned pixels_queued = 0;
  int unsigned pixels_taken  = 0;
  int unsigned results_seen  = 0;
  int unsigned mismatches    = 0;
  int unsigned stall_cycles  = 0;
  logic        in_taken      = 1'b0;
  logic        cfg_taken     = 1'b0;
  logic        out_hold      = 1'b0;
  logic        hold_req      = 1'b0;
  logic        steady        = 1'b0;

  function automatic int unsigned clamp_dim(logic [SIZE_W-1:0] v, int unsigned lim);
    if (v < 3) return 3;
    if (v > lim) return lim;
    return 32'(v);
  endfunction

  function automatic void load_reg(logic [CFG_IDX_W-1:0] idx, logic [CROW_W-1:0] d);
    case (idx)
      CFG_COLOR_MODE: color_rgb = d[0];
      CFG_WIDTH:      img_w = d[SIZE_W-1:0];
      CFG_HEIGHT:     img_h = d[SIZE_W-1:0];
      CFG_COEF_TOP:   coefs[0] = d;
      CFG_COEF_MID:   coefs[1] = d;
      CFG_COEF_BOT:   coefs[2] = d;
      default: ;
    endcase
  endfunction

  // nine-tap sum of one channel, floored and clamped to a byte
  function automatic logic [CH_W-1:0] tap_sum(int unsigned sh);
    int acc, k, p;
    int unsigned n, m;
    acc = 0;
    for (n = 0; n < 3; n++) begin
      for (m = 0; m < 3; m++) begin
        k = 32'($signed(coefs[n][m*COEF_W +: COEF_W]));
        p = 32'(window[n][m][sh +: CH_W]);
        acc += k * p;
      end
    end
    if (acc < 0) return '0;
    acc = acc >>> FRAC_W;
    return (acc > 255) ? 8'hFF : acc[CH_W-1:0];
  endfunction

  function automatic void filter_pixel(pix_in_t px);
    rgb_t        pix, above, above2;
    int unsigned w, h, idx, n;
    logic        line_end, frame_end;
    pix_out_t    res;
    w = clamp_dim(img_w, MAX_W);
    h = clamp_dim(img_h, MAX_H);
    pix = {px.blue_in, px.green_in, px.red_in};
    idx = (col_pos < MAX_W) ? col_pos : MAX_W - 1;
    above  = line_a[idx];
    above2 = line_b[idx];
    line_b[idx] = above;
    seen_b[idx] = seen_a[idx];
    line_a[idx] = pix;
    seen_a[idx] = 1'b1;
    for (n = 0; n < 3; n++) begin
      window[n][0] = window[n][1];
      window[n][1] = window[n][2];
    end
    window[0][2] = above2;
    window[1][2] = above;
    window[2][2] = pix;
    line_end  = col_pos >= w - 1;
    frame_end = line_end && row_pos >= h - 1;
    if (row_pos >= 2 && col_pos >= 2) begin
      res.red_out    = tap_sum(0);
      res.green_out  = color_rgb ? tap_sum(CH_W) : '0;
      res.blue_out   = color_rgb ? tap_sum(2 * CH_W) : '0;
      res.frame_last = frame_end;
      filtered_due.push_back(res);
    end
    if (line_end) begin
      col_pos = 0;
      row_pos = frame_end ? 0 : row_pos + 1;
    end else begin
      col_pos++;
    end
  endfunction

  task automatic report(string field, int got, int want);
    if (mismatches < PRINT_CAP)
      $display("result %0d %s: got %0d, expected %0d", results_seen, field, got, want);
    mismatches++;
  endtask

  task automatic check_result(pix_out_t got);
    pix_out_t want;
    results_seen++;
    if (filtered_due.size() == 0) begin
      report("unexpected word, red", int'(got.red_out), 0);
      return;
    end
    want = filtered_due.pop_front();
    if (got.red_out !== want.red_out)
      report("red", int'(got.red_out), int'(want.red_out));
    if (got.green_out !== want.green_out)
      report("green", int'(got.green_out), int'(want.green_out));
    if (got.blue_out !== want.blue_out)
      report("blue", int'(got.blue_out), int'(want.blue_out));
    if (got.frame_last !== want.frame_last)
      report("frame_last", int'(got.frame_last), int'(want.frame_last));
  endtask

  // sampling, prediction, checking and watchdog
  always @(posedge clk_i) begin
    if (rst_ni) begin
      in_taken  <= in_valid_i && in_ready_o;
      cfg_taken <= cfg_valid_i && cfg_ready_o;
      if (cfg_valid_i && cfg_ready_o) load_reg(cfg_index_i, cfg_data_i);
      if (in_valid_i && in_ready_o) begin
        filter_pixel(in_data_i);
        pixels_taken <= pixels_taken + 1;
      end
      if (out_valid_o && out_ready_i) check_result(out_data_o);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
          (cfg_valid_i && cfg_ready_o)) begin
        stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
        $display("conv3x3_image_filter: mismatch");
        $finish;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
    end
  end

  // pixel driver: word held until taken
  always @(negedge clk_i) begin
    if (!in_valid_i || in_taken) begin
      if (pixel_backlog.size() > 0 && (steady || $urandom_range(0, 99) >= IDLE_PCT)) begin
        in_valid_i <= 1'b1;
        in_data_i  <= pixel_backlog.pop_front();
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  always @(negedge clk_i)
    out_ready_i <= !out_hold && (steady || $urandom_range(0, 99) >= IDLE_PCT);

  // long output back-pressure
  initial begin
    wait (hold_req);
    @(posedge clk_i);
    out_hold = 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk_i);
    out_hold = 1'b0;
  end

  // stretch with no idling on either side
  initial begin
    wait (pixels_taken >= STEADY_AT);
    @(posedge clk_i);
    steady = 1'b1;
    repeat (STEADY_CYCLES) @(posedge clk_i);
    steady = 1'b0;
  end

  function automatic logic [CH_W-1:0] rand_chan();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return '1;
      default: return CH_W'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic void queue_pixels(int unsigned n, fill_e fill);
    pix_in_t     px;
    int unsigned i;
    for (i = 0; i < n; i++) begin
      case (fill)
        PIX_WHITE: px = '1;
        PIX_BLACK: px = '0;
        default: begin
          px.red_in   = rand_chan();
          px.green_in = rand_chan();
          px.blue_in  = rand_chan();
        end
      endcase
      pixel_backlog.push_back(px);
      pixels_queued++;
    end
  endfunction

  function automatic logic [CROW_W-1:0] junk_word();
    logic [CROW_W-1:0] j;
    j[47:32] = 16'($urandom_range(0, 65535));
    j[31:0]  = $urandom;
    return j;
  endfunction

  function automatic logic [CROW_W-1:0] rand_coef_row();
    logic [CROW_W-1:0] r;
    int                k;
    int unsigned       m;
    for (m = 0; m < 3; m++) begin
      k = $urandom_range(0, 1200);
      k = k - 600;
      case ($urandom_range(0, 5))
        0:       r[m*COEF_W +: COEF_W] = 16'h7FFF;
        1:       r[m*COEF_W +: COEF_W] = 16'h8000;
        2:       r[m*COEF_W +: COEF_W] = COEF_W'($urandom_range(0, 65535));
        default: r[m*COEF_W +: COEF_W] = k[COEF_W-1:0];
      endcase
    end
    return r;
  endfunction

  function automatic logic [SIZE_W-1:0] rand_width();
    case ($urandom_range(0, 9))
      0:       return SIZE_W'($urandom_range(0, 2));
      1:       return SIZE_W'($urandom_range(13, 40));
      default: return SIZE_W'($urandom_range(3, 10));
    endcase
  endfunction

  function automatic logic [SIZE_W-1:0] rand_height();
    if ($urandom_range(0, 7) == 0) return SIZE_W'($urandom_range(0, 2));
    return SIZE_W'($urandom_range(3, 6));
  endfunction

  // a width change must not make a later window read a never-written line entry
  function automatic bit width_ok(logic [SIZE_W-1:0] v);
    int unsigned w, i;
    if (row_pos == 0) return 1'b1;
    w = clamp_dim(v, MAX_W);
    for (i = 0; i < w; i++)
      if (!(seen_a[i] && seen_b[i])) return 1'b0;
    return 1'b1;
  endfunction

  function automatic int unsigned pixels_to_frame_end();
    int unsigned w, h, cols, rows;
    w = clamp_dim(img_w, MAX_W);
    h = clamp_dim(img_h, MAX_H);
    cols = (col_pos >= w - 1) ? 1 : w - col_pos;
    rows = (row_pos >= h - 1) ? 0 : h - 1 - row_pos;
    return cols + rows * w;
  endfunction

  task automatic settle();
    do @(negedge clk_i);
    while (pixels_taken != pixels_queued || filtered_due.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CROW_W-1:0] d);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= d;
    do @(negedge clk_i); while (!cfg_taken);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic set_mode(logic rgb);
    logic [CROW_W-1:0] d;
    d    = junk_word();
    d[0] = rgb;
    write_reg(CFG_COLOR_MODE, d);
  endtask

  task automatic set_size(logic [CFG_IDX_W-1:0] idx, logic [SIZE_W-1:0] v);
    logic [CROW_W-1:0] d;
    d             = junk_word();
    d[SIZE_W-1:0] = v;
    write_reg(idx, d);
  endtask

  task automatic close_frame();
    queue_pixels(pixels_to_frame_end(), PIX_RANDOM);
    settle();
  endtask

  initial begin
    int unsigned       start_cnt;
    logic [SIZE_W-1:0] nw;

    repeat (3) @(negedge clk_i);
    rst_ni <= 1'b1;

    // reset coefficients (box blur), gray
    set_size(CFG_WIDTH, SIZE_W'(3));
    set_size(CFG_HEIGHT, SIZE_W'(3));
    queue_pixels(9, PIX_WHITE);
    queue_pixels(9, PIX_BLACK);
    settle();

    set_mode(1'b1);
    queue_pixels(9, PIX_RANDOM);
    settle();

    write_reg(CFG_COEF_TOP, {3{16'h7FFF}});
    write_reg(CFG_COEF_MID, {3{16'h8000}});
    write_reg(CFG_COEF_BOT, {3{16'hFFFF}});
    write_reg(CFG_UNUSED, '1);
    queue_pixels(9, PIX_WHITE);
    queue_pixels(9, PIX_RANDOM);
    settle();

    // mode flip inside a frame
    write_reg(CFG_COEF_TOP, {16'h0100, 16'hFF00, 16'h0100});
    write_reg(CFG_COEF_MID, {16'hFE00, 16'h1000, 16'hFE00});
    write_reg(CFG_COEF_BOT, rand_coef_row());
    set_size(CFG_WIDTH, SIZE_W'(6));
    set_size(CFG_HEIGHT, SIZE_W'(4));
    queue_pixels(15, PIX_RANDOM);
    settle();
    set_mode(1'b0);
    queue_pixels(6, PIX_RANDOM);
    settle();
    // narrower line mid-frame wraps and ends the frame
    set_size(CFG_WIDTH, SIZE_W'(3));
    close_frame();

    // sizes below range clamp to 3
    set_size(CFG_WIDTH, SIZE_W'(0));
    set_size(CFG_HEIGHT, SIZE_W'(2));
    set_mode(1'b1);
    close_frame();

    // wider frame while the output is held off
    write_reg(CFG_COEF_TOP, COEF_RESET);
    write_reg(CFG_COEF_MID, COEF_RESET);
    write_reg(CFG_COEF_BOT, COEF_RESET);
    set_size(CFG_WIDTH, SIZE_W'(20));
    set_size(CFG_HEIGHT, SIZE_W'(3));
    hold_req = 1'b1;
    close_frame();

    // tallest frame, cut short by a height change
    set_size(CFG_WIDTH, SIZE_W'(1));
    set_size(CFG_HEIGHT, 12'hFFF);
    queue_pixels(30, PIX_RANDOM);
    settle();
    set_size(CFG_HEIGHT, SIZE_W'(0));
    close_frame();

    start_cnt = pixels_queued;
    while (pixels_queued - start_cnt < RANDOM_PIXELS) begin
      if ((col_pos != 0 || row_pos != 0) && $urandom_range(0, 4) == 0) close_frame();
      if ($urandom_range(0, 2) == 0) set_mode(1'($urandom_range(0, 1)));
      if ($urandom_range(0, 3) == 0) write_reg(CFG_COEF_TOP, rand_coef_row());
      if ($urandom_range(0, 3) == 0) write_reg(CFG_COEF_MID, rand_coef_row());
      if ($urandom_range(0, 3) == 0) write_reg(CFG_COEF_BOT, rand_coef_row());
      if ($urandom_range(0, 2) == 0) begin
        nw = rand_width();
        if (width_ok(nw)) set_size(CFG_WIDTH, nw);
      end
      if ($urandom_range(0, 3) == 0) set_size(CFG_HEIGHT, rand_height());
      queue_pixels($urandom_range(1, 30), PIX_RANDOM);
      settle();
    end
    close_frame();

    if (mismatches == 0) begin
      $display("conv3x3_image_filter: match");
    end else begin
      $display("conv3x3_image_filter: mismatch");
    end
    $finish;
  end

endmodule

### filelist.f
rtl/c3f_pkg.sv
rtl/c3f_ram.sv
rtl/c3f_window.sv
rtl/c3f_conv.sv
rtl/conv3x3_image_filter.sv
tb/conv3x3_image_filter_test.sv
